// File: src/bpv_pkg.sv
// shared types and constants for the byte plurality voter
package bpv_pkg;

  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned HERE_W    = 3;
  localparam int unsigned TOTAL_W   = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [NUM_LANES*BYTE_W-1:0] copy_bytes;
    logic [NUM_LANES-1:0]        copy_present;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  voted_byte;
    logic               byte_valid;
    logic [HERE_W-1:0]  differences_here;
  } vote_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  voted_byte;
    logic               byte_valid;
    logic [HERE_W-1:0]  differences_here;
    logic [TOTAL_W-1:0] differences_total;
  } out_word_t;

endpackage

// File: src/byte_plurality_voter_unit.sv
// top level of the byte plurality voter: input register, vote, result register
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one word per position,
// carrying the eight copy bytes and the mask of copies still present.
// Output channel (out_valid_o / out_stall_i / out_data_o): one word per input
// word, in order: the voted byte, a valid flag (0 marks end of data), the
// number of distinct values minus one, and the saturating running total.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the number
// of copy lanes in use; always ready, write only while the unit is idle.
// A word accepted into the input register is voted on and then held in the result register, which drives the output.
// Throughput is one word per cycle while out_stall_i is low: the vote network sits
// between the input register and the result register, and each stage advances every cycle.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall_o rises once both are occupied and out_stall_i is high.
// Reset clears both stages, sets the lane count to 3 and the total to zero.
module byte_plurality_voter_unit #(
  parameter int unsigned MAX_COPIES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpv_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpv_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bpv_pkg::out_word_t          out_data_o
);

  logic [bpv_pkg::CFG_W-1:0]   copies_in_use_q;
  logic                        in_valid_q;
  bpv_pkg::in_word_t           in_q;
  logic                        out_valid_q;
  bpv_pkg::out_word_t          out_q;
  logic [bpv_pkg::TOTAL_W-1:0] total_q;
  logic [bpv_pkg::TOTAL_W-1:0] total_d;
  logic [bpv_pkg::TOTAL_W:0]   total_sum;
  bpv_pkg::vote_t              vote;
  logic                        advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copies_in_use_q <= bpv_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      copies_in_use_q <= cfg_data_i;
    end
  end

  bpv_vote #(
    .MAX_COPIES (MAX_COPIES)
  ) u_vote (
    .item_i          (in_q),
    .copies_in_use_i (copies_in_use_q),
    .vote_o          (vote)
  );

  // saturating add of this word's differences
  assign total_sum = {1'b0, total_q} + {{(bpv_pkg::TOTAL_W + 1 - bpv_pkg::HERE_W){1'b0}},
                                        vote.differences_here};
  assign total_d   = total_sum[bpv_pkg::TOTAL_W] ? bpv_pkg::TOTAL_MAX
                                                 : total_sum[bpv_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q.voted_byte        <= vote.voted_byte;
      out_q.byte_valid        <= vote.byte_valid;
      out_q.differences_here  <= vote.differences_here;
      out_q.differences_total <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/bpv_vote.sv
// combinational plurality vote network over the active copy lanes
module bpv_vote #(
  parameter int unsigned MAX_COPIES = 8
) (
  input  bpv_pkg::in_word_t              item_i,
  input  logic [bpv_pkg::CFG_W-1:0]      copies_in_use_i,
  output bpv_pkg::vote_t                 vote_o
);

  localparam int unsigned CNT_W = $clog2(MAX_COPIES + 1);

  logic [bpv_pkg::CFG_W-1:0]                   lanes;
  logic [MAX_COPIES-1:0][bpv_pkg::BYTE_W-1:0]  val;
  logic [MAX_COPIES-1:0]                       use_lane;
  logic [MAX_COPIES-1:0][MAX_COPIES-1:0]       match;
  logic [MAX_COPIES-1:0][CNT_W-1:0]            cnt;
  logic [MAX_COPIES-1:0]                       first;
  logic [MAX_COPIES-1:0]                       win;
  logic [CNT_W-1:0]                            distinct;
  logic [bpv_pkg::BYTE_W-1:0]                  voted;

  // clamp the lane count into 1..MAX_COPIES
  always_comb begin
    if (copies_in_use_i == '0) begin
      lanes = bpv_pkg::CFG_W'(1);
    end else if (copies_in_use_i > bpv_pkg::CFG_W'(MAX_COPIES)) begin
      lanes = bpv_pkg::CFG_W'(MAX_COPIES);
    end else begin
      lanes = copies_in_use_i;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_COPIES; i++) begin
      val[i]      = item_i.copy_bytes[bpv_pkg::BYTE_W*i +: bpv_pkg::BYTE_W];
      use_lane[i] = item_i.copy_present[i] && (bpv_pkg::CFG_W'(i) < lanes);
    end
  end

  // pairwise equality among present lanes, then per-lane counts
  always_comb begin
    for (int i = 0; i < MAX_COPIES; i++) begin
      first[i] = use_lane[i];
      for (int j = 0; j < MAX_COPIES; j++) begin
        match[i][j] = use_lane[j] && (val[j] == val[i]);
        if (match[i][j] && (j < i)) begin
          first[i] = 1'b0;
        end
      end
      cnt[i] = CNT_W'($countones(match[i]));
    end
  end

  // a lane wins when no present lane beats it on count, or ties with a smaller byte
  always_comb begin
    for (int i = 0; i < MAX_COPIES; i++) begin
      win[i] = use_lane[i];
      for (int j = 0; j < MAX_COPIES; j++) begin
        if (use_lane[j] && ((cnt[j] > cnt[i]) ||
                            ((cnt[j] == cnt[i]) && (val[j] < val[i])))) begin
          win[i] = 1'b0;
        end
      end
    end
  end

  // all winning lanes carry the same byte
  always_comb begin
    voted = '0;
    for (int i = MAX_COPIES - 1; i >= 0; i--) begin
      if (win[i]) begin
        voted = val[i];
      end
    end
  end

  assign distinct = CNT_W'($countones(first));

  always_comb begin
    vote_o.byte_valid = |use_lane;
    if (vote_o.byte_valid) begin
      vote_o.voted_byte       = voted;
      vote_o.differences_here = bpv_pkg::HERE_W'(distinct - CNT_W'(1));
    end else begin
      vote_o.voted_byte       = '0;
      vote_o.differences_here = '0;
    end
  end

endmodule

// File: bench/tb_byte_plurality_voter_unit.sv
// testbench for byte_plurality_voter_unit: random and directed words checked against a vote tally
module tb_byte_plurality_voter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned PHASE_WORDS  = 225;
  localparam int unsigned NUM_PHASES   = 8;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_e;

  class vote_tracker;
    logic [bpv_pkg::CFG_W-1:0]   lane_count;
    logic [bpv_pkg::TOTAL_W-1:0] total;
    bpv_pkg::out_word_t          expected_votes[$];
    int unsigned                 failures;

    function new();
      lane_count = bpv_pkg::CFG_RESET;
      total      = '0;
      failures   = 0;
    endfunction

    function void set_lane_count(logic [bpv_pkg::CFG_W-1:0] count);
      lane_count = count;
    endfunction

    // plurality vote over the active present lanes, smallest value wins a tie
    function bpv_pkg::out_word_t tally_vote(bpv_pkg::in_word_t w);
      bpv_pkg::out_word_t         res;
      int unsigned                lanes;
      int unsigned                best_count;
      int unsigned                cnt;
      int unsigned                distinct;
      logic [bpv_pkg::BYTE_W-1:0] best_val;
      logic [bpv_pkg::BYTE_W-1:0] lane_byte[bpv_pkg::NUM_LANES];
      bit                         counted[bpv_pkg::NUM_LANES];
      bit                         first_seen;
      logic [bpv_pkg::HERE_W-1:0] here;
      lanes = lane_count;
      if (lanes < 1) lanes = 1;
      if (lanes > bpv_pkg::NUM_LANES) lanes = bpv_pkg::NUM_LANES;
      best_count = 0;
      best_val   = '0;
      distinct   = 0;
      for (int i = 0; i < bpv_pkg::NUM_LANES; i++) begin
        lane_byte[i] = w.copy_bytes[bpv_pkg::BYTE_W*i +: bpv_pkg::BYTE_W];
        counted[i]   = (i < lanes) && (w.copy_present[i] == 1'b1);
      end
      for (int i = 0; i < bpv_pkg::NUM_LANES; i++) begin
        if (!counted[i]) continue;
        cnt        = 0;
        first_seen = 1'b1;
        for (int j = 0; j < bpv_pkg::NUM_LANES; j++) begin
          if (counted[j] && lane_byte[j] == lane_byte[i]) begin
            cnt++;
            if (j < i) first_seen = 1'b0;
          end
        end
        if (first_seen) distinct++;
        if (cnt > best_count || (cnt == best_count && lane_byte[i] < best_val)) begin
          best_count = cnt;
          best_val   = lane_byte[i];
        end
      end
      res = '0;
      // end of data: nothing present, total repeats unchanged
      if (distinct == 0) begin
        res.differences_total = total;
        return res;
      end
      here = bpv_pkg::HERE_W'(distinct - 1);
      if (bpv_pkg::TOTAL_MAX - total < bpv_pkg::TOTAL_W'(here)) total = bpv_pkg::TOTAL_MAX;
      else total = total + bpv_pkg::TOTAL_W'(here);
      res.voted_byte        = best_val;
      res.byte_valid        = 1'b1;
      res.differences_here  = here;
      res.differences_total = total;
      return res;
    endfunction

    function void note_input(bpv_pkg::in_word_t w);
      expected_votes.push_back(tally_vote(w));
    endfunction

    function void check_result(bpv_pkg::out_word_t got);
      bpv_pkg::out_word_t want;
      if (expected_votes.size() == 0) begin
        $error("result word with none expected: voted_byte %0h total %0d",
               got.voted_byte, got.differences_total);
        failures++;
        return;
      end
      want = expected_votes.pop_front();
      if (got.voted_byte !== want.voted_byte) begin
        $error("voted_byte: expected %0h, actual %0h", want.voted_byte, got.voted_byte);
        failures++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
        failures++;
      end
      if (got.differences_here !== want.differences_here) begin
        $error("differences_here: expected %0d, actual %0d",
               want.differences_here, got.differences_here);
        failures++;
      end
      if (got.differences_total !== want.differences_total) begin
        $error("differences_total: expected %0d, actual %0d",
               want.differences_total, got.differences_total);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_votes.size();
    endfunction

    function void report_leftovers();
      if (expected_votes.size() != 0) begin
        $error("%0d expected result words never arrived", expected_votes.size());
        failures += expected_votes.size();
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [bpv_pkg::CFG_W-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  bpv_pkg::in_word_t           in_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  bpv_pkg::out_word_t          out_data_o;

  vote_tracker        tracker;
  int unsigned        burst_left;
  int unsigned        cycle_count;

  byte_plurality_voter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_byte_plurality_voter_unit NOT OK");
    $finish;
  end

  // receiver stalls in runs of random length and density
  initial begin
    stall_mode_e mode;
    int unsigned run_len;
    out_stall_i <= 1'b0;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) tracker.note_input(in_data_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) tracker.check_result(out_data_o);
    end
  end

  // sender works in bursts, each new burst may open with a random gap
  task automatic send_word(input bpv_pkg::in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_lanes(input logic [63:0] bytes, input logic [7:0] present);
    bpv_pkg::in_word_t w;
    w.copy_bytes   = bytes;
    w.copy_present = present;
    send_word(w);
  endtask

  task automatic write_lane_count(input logic [bpv_pkg::CFG_W-1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    tracker.set_lane_count(count);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic bpv_pkg::in_word_t make_word();
    bpv_pkg::in_word_t          w;
    logic [bpv_pkg::BYTE_W-1:0] base;
    logic [bpv_pkg::BYTE_W-1:0] alt;
    logic [bpv_pkg::BYTE_W-1:0] b;
    int unsigned                kind;
    int unsigned                pick;
    kind = $urandom_range(0, 99);
    base = bpv_pkg::BYTE_W'($urandom);
    alt  = bpv_pkg::BYTE_W'($urandom);
    for (int k = 0; k < bpv_pkg::NUM_LANES; k++) begin
      if (kind < 55) begin
        // redundant copies that mostly agree, with the odd corrupted byte
        b = base;
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) b = bpv_pkg::BYTE_W'($urandom);
          else b = base ^ (8'h01 << $urandom_range(0, 7));
        end
      end else if (kind < 80) begin
        // a few contending values, so ties come up often
        pick = $urandom_range(0, 2);
        b = (pick == 0) ? base : (pick == 1) ? alt : (base ^ alt);
      end else begin
        b = bpv_pkg::BYTE_W'($urandom);
      end
      w.copy_bytes[bpv_pkg::BYTE_W*k +: bpv_pkg::BYTE_W] = b;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) w.copy_present = 8'hFF;
    else if (pick < 75) w.copy_present = 8'hFF >> $urandom_range(0, 8);
    else if (pick < 95) w.copy_present = bpv_pkg::NUM_LANES'($urandom);
    else w.copy_present = 8'h00;
    return w;
  endfunction

  initial begin
    logic [bpv_pkg::CFG_W-1:0] phase_lanes[NUM_PHASES];
    tracker     = new();
    burst_left  = 0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset lane count of three: upper lanes must be ignored
    send_lanes(64'h0102_0304_0541_4141, 8'hFF);
    send_lanes(64'h5555_5555_55AA_55AA, 8'hFF);
    send_lanes(64'h1111_2222_3344_5566, 8'hF8);
    send_lanes(64'hDEAD_BEEF_0123_4567, 8'h00);
    // words after end of data are still voted
    send_lanes(64'h0000_0000_0030_2010, 8'h07);
    wait_drained();

    write_lane_count(4'd8);
    send_lanes(64'h0000_0000_0000_0000, 8'hFF);
    send_lanes(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_lanes(64'hF0F1_F2F3_F4F5_F6F7, 8'hFF);
    send_lanes(64'h7F7F_7F7F_8080_8080, 8'hFF);
    send_lanes(64'h0000_00FF_FFFF_FFFF, 8'hFF);
    send_lanes(64'hC300_0000_0000_0000, 8'h80);
    send_lanes(64'h1234_5678_9ABC_DEF0, 8'h00);
    send_lanes(64'h5AA5_5AA5_5AA5_5AA5, 8'hAA);
    send_lanes(64'hFFFF_FFFF_FFFF_FFFF, 8'h01);
    send_lanes(64'h0123_4567_89AB_CDEF, 8'hFF);
    send_lanes(64'hA5A5_A5A5_5A5A_5A5A, 8'h55);
    wait_drained();

    // zero and values above eight exercise the clamping
    phase_lanes = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd2, 4'd9, 4'd5, 4'd3};
    phase_lanes[6] = bpv_pkg::CFG_W'($urandom_range(0, 15));
    phase_lanes[7] = bpv_pkg::CFG_W'($urandom_range(0, 15));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_lane_count(phase_lanes[p]);
      repeat (PHASE_WORDS) send_word(make_word());
      wait_drained();
    end

    tracker.report_leftovers();
    if (tracker.failures == 0) $display("tb_byte_plurality_voter_unit OK");
    else $display("tb_byte_plurality_voter_unit NOT OK");
    $finish;
  end

endmodule

// File: byte_plurality_voter_unit.f
src/bpv_pkg.sv
src/bpv_vote.sv
src/byte_plurality_voter_unit.sv
bench/tb_byte_plurality_voter_unit.sv
